// ----- rtl/xor_checksum_frame_builder_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the XOR checksum frame builder
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef XOR_CHECKSUM_FRAME_BUILDER_DEFINES_SVH
`define XOR_CHECKSUM_FRAME_BUILDER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define XCFB_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define XCFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/xcfb_pkg.sv -----
// ----------------------------------------------------------------------------
// xcfb_pkg
// Types and constants shared by the XOR checksum frame builder.
// ----------------------------------------------------------------------------
package xcfb_pkg;

    localparam int unsigned ByteW      = 8;
    localparam int unsigned MaxResults = 5;
    localparam int unsigned CntW       = $clog2(MaxResults + 1);
    localparam int unsigned IdxW       = $clog2(MaxResults);
    localparam int unsigned CfgAddrW   = 2;

    localparam logic [ByteW:0]   FrameOverhead = 9'd5;
    localparam logic [ByteW-1:0] BodyExtra     = 8'd2;

    localparam logic [ByteW-1:0] HeadReset   = 8'd170;
    localparam logic [ByteW-1:0] TailReset   = 8'd85;
    localparam logic [ByteW-1:0] MaxLenReset = 8'd64;

    typedef enum logic {
        REQ_START = 1'b0,
        REQ_BYTE  = 1'b1
    } req_t;

    typedef enum logic [CfgAddrW-1:0] {
        CFG_HEAD    = 2'd0,
        CFG_TAIL    = 2'd1,
        CFG_MAX_LEN = 2'd2
    } cfg_addr_t;

    typedef struct packed {
        logic [ByteW-1:0] head_byte;
        logic [ByteW-1:0] tail_byte;
        logic [ByteW-1:0] max_frame_len;
    } cfg_t;

    typedef struct packed {
        logic [ByteW-1:0] data;
        logic [ByteW-1:0] pld_len;
        logic [ByteW-1:0] cmd;
        logic [ByteW-1:0] channel;
        req_t             req_type;
    } item_t;

    typedef struct packed {
        logic             error;
        logic             frame_end;
        logic [ByteW-1:0] out_channel;
        logic [ByteW-1:0] out_byte;
    } result_t;

    typedef struct packed {
        result_t [MaxResults-1:0] res;
        logic    [CntW-1:0]       count;
    } bundle_t;

endpackage

// ----- rtl/xcfb_core.sv -----
// ----------------------------------------------------------------------------
// xcfb_core
// Frame state and the per-item result list.
// ----------------------------------------------------------------------------
module xcfb_core
    import xcfb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    accept,
    input  item_t   item,
    input  cfg_t    cfg,
    output bundle_t bundle
);

    logic             frame_open_reg, frame_open_next;
    logic [ByteW-1:0] bytes_left_reg, bytes_left_next;
    logic [ByteW-1:0] running_xor_reg, running_xor_next;
    logic [ByteW-1:0] frame_channel_reg, frame_channel_next;

    logic             too_long;
    logic [ByteW-1:0] len_field;
    logic [ByteW-1:0] start_xor;
    logic [ByteW-1:0] byte_xor;
    logic [ByteW-1:0] left_dec;

    assign too_long  = ({1'b0, item.pld_len} + FrameOverhead) > {1'b0, cfg.max_frame_len};
    assign len_field = item.pld_len + BodyExtra;
    assign start_xor = len_field ^ item.cmd;
    assign byte_xor  = running_xor_reg ^ item.data;
    assign left_dec  = bytes_left_reg - 8'd1;

    always_comb
    begin
        frame_open_next    = frame_open_reg;
        bytes_left_next    = bytes_left_reg;
        running_xor_next   = running_xor_reg;
        frame_channel_next = frame_channel_reg;
        bundle             = '0;

        if (item.req_type == REQ_START)
        begin
            if (too_long)
            begin
                bundle.res[0] = '{error: 1'b1, frame_end: 1'b1,
                                  out_channel: item.channel, out_byte: '0};
                bundle.count  = CntW'(1);
            end
            else
            begin
                frame_channel_next = item.channel;
                running_xor_next   = start_xor;
                bundle.res[0] = '{1'b0, 1'b0, item.channel, cfg.head_byte};
                bundle.res[1] = '{1'b0, 1'b0, item.channel, len_field};
                bundle.res[2] = '{1'b0, 1'b0, item.channel, item.cmd};
                if (item.pld_len == '0)
                begin
                    // empty payload: trailer follows at once, frame closes
                    bundle.res[3]   = '{1'b0, 1'b0, item.channel, start_xor};
                    bundle.res[4]   = '{1'b0, 1'b1, item.channel, cfg.tail_byte};
                    bundle.count    = CntW'(5);
                    frame_open_next = 1'b0;
                    bytes_left_next = '0;
                end
                else
                begin
                    bundle.count    = CntW'(3);
                    frame_open_next = 1'b1;
                    bytes_left_next = item.pld_len;
                end
            end
        end
        else if (!frame_open_reg)
        begin
            bundle.res[0] = '{error: 1'b1, frame_end: 1'b1, out_channel: '0, out_byte: '0};
            bundle.count  = CntW'(1);
        end
        else
        begin
            running_xor_next = byte_xor;
            bundle.res[0]    = '{1'b0, 1'b0, frame_channel_reg, item.data};
            if (left_dec == '0)
            begin
                bundle.res[1]   = '{1'b0, 1'b0, frame_channel_reg, byte_xor};
                bundle.res[2]   = '{1'b0, 1'b1, frame_channel_reg, cfg.tail_byte};
                bundle.count    = CntW'(3);
                frame_open_next = 1'b0;
                bytes_left_next = '0;
            end
            else
            begin
                bundle.count    = CntW'(1);
                bytes_left_next = left_dec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg    <= 1'b0;
            bytes_left_reg    <= '0;
            running_xor_reg   <= '0;
            frame_channel_reg <= '0;
        end
        else if (accept)
        begin
            frame_open_reg    <= frame_open_next;
            bytes_left_reg    <= bytes_left_next;
            running_xor_reg   <= running_xor_next;
            frame_channel_reg <= frame_channel_next;
        end
    end

endmodule

// ----- rtl/xor_checksum_frame_builder.sv -----
// ----------------------------------------------------------------------------
// xor_checksum_frame_builder
// Length-prefixed transmit frame builder with an XOR checksum.
// ----------------------------------------------------------------------------
// Each input item is decoded in the cycle it is accepted: frame state updates
// at once and its list of one to five result items is captured in a result
// list register. A drain stage moves the list, one item per cycle while the
// output register is free, into the output register. A start item yields
// head, length and command (plus checksum and tail for an empty payload); a
// payload byte yields that byte (plus checksum and tail on the last byte); a
// refused start or a stray byte yields one error item. The input takes one
// item per cycle, unless the output stalls, as long as each item yields a
// single result; an item yielding more holds the input until its list drains.
// Results pass the result list and output registers. The input is taken while
// the output register is stalled, as long as the result list is drained.
// ----------------------------------------------------------------------------
module xor_checksum_frame_builder
    import xcfb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration write port
    input  logic                cfg_we,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic [ByteW-1:0]    cfg_wdata,
    // input items
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,   // channel, cmd, pld_len, data
    input  logic                s_tuser,   // req_type
    // result items
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,   // out_byte, out_channel
    output logic                m_tlast,   // frame_end
    output logic                m_tuser    // error
);

    cfg_t    cfg_reg;
    item_t   item;
    bundle_t bundle_new;

    result_t [MaxResults-1:0] list_reg;
    logic    [CntW-1:0]       list_cnt_reg;
    logic    [IdxW-1:0]       list_idx_reg;
    logic                     list_valid_reg;

    result_t out_reg;
    logic    out_valid_reg;

    logic accept;
    logic out_free;
    logic move;
    logic last_move;

    // Configuration registers; writes to unused indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.head_byte     <= HeadReset;
            cfg_reg.tail_byte     <= TailReset;
            cfg_reg.max_frame_len <= MaxLenReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_HEAD:    cfg_reg.head_byte     <= cfg_wdata;
                CFG_TAIL:    cfg_reg.tail_byte     <= cfg_wdata;
                CFG_MAX_LEN: cfg_reg.max_frame_len <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    // Unpack the input item.
    assign item.req_type = req_t'(s_tuser);
    assign item.channel  = s_tdata[7:0];
    assign item.cmd      = s_tdata[15:8];
    assign item.pld_len  = s_tdata[23:16];
    assign item.data     = s_tdata[31:24];

    // Handshake: output register frees when empty or taken; the list frees
    // once its last entry moves out.
    assign out_free  = !out_valid_reg || m_tready;
    assign move      = list_valid_reg && out_free;
    assign last_move = move && ((CntW'(list_idx_reg) + CntW'(1)) == list_cnt_reg);
    assign s_tready  = !list_valid_reg || last_move;
    assign accept    = s_tvalid && s_tready;

    xcfb_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cfg    (cfg_reg),
        .bundle (bundle_new)
    );

    // Result list control: load on accept, advance on each move.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_valid_reg <= 1'b0;
            list_idx_reg   <= '0;
            list_cnt_reg   <= '0;
        end
        else if (accept)
        begin
            list_valid_reg <= 1'b1;
            list_idx_reg   <= '0;
            list_cnt_reg   <= bundle_new.count;
        end
        else if (last_move)
        begin
            list_valid_reg <= 1'b0;
        end
        else if (move)
        begin
            list_idx_reg <= list_idx_reg + IdxW'(1);
        end
    end

    // Result list payload; no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            list_reg <= bundle_new.res;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_reg <= list_reg[list_idx_reg];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.out_channel, out_reg.out_byte};
    assign m_tlast  = out_reg.frame_end;
    assign m_tuser  = out_reg.error;

endmodule

// ----- rtl/xcfb_checker.sv -----
// ----------------------------------------------------------------------------
// xcfb_checker
// Port-level checks for the XOR checksum frame builder.
// ----------------------------------------------------------------------------
`include "xor_checksum_frame_builder_defines.svh"

module xcfb_checker
    import xcfb_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [15:0]         m_tdata,
    input logic                m_tlast,
    input logic                m_tuser
);

    // an error item always closes the run
    `XCFB_ASSERT_SAME(a_err_ends, clk, rst_n, m_tvalid && m_tuser, m_tlast)

    // an error item carries no wire byte
    `XCFB_ASSERT_SAME(a_err_zero, clk, rst_n, m_tvalid && m_tuser, m_tdata[7:0] == 8'd0)

    // a stalled result holds
    `XCFB_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
                      m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

endmodule

bind xor_checksum_frame_builder xcfb_checker u_xcfb_checker (.*);
